// ===== design/tgr_pkg.sv =====
`timescale 1ns / 1ps
// shared types and codes for the touch gesture recogniser
package tgr_pkg;

    // event kinds on the input side
    localparam logic [1:0] MODE_PRESS   = 2'd0;
    localparam logic [1:0] MODE_RELEASE = 2'd1;
    localparam logic [1:0] MODE_TICK    = 2'd2;
    localparam logic [1:0] MODE_CLEAR   = 2'd3;

    // gesture codes on the result side
    localparam logic [2:0] G_DOWN      = 3'd0;
    localparam logic [2:0] G_UP        = 3'd1;
    localparam logic [2:0] G_SINGLE    = 3'd2;
    localparam logic [2:0] G_DOUBLE    = 3'd3;
    localparam logic [2:0] G_LONG      = 3'd4;
    localparam logic [2:0] G_VERY_LONG = 3'd5;

    // register indexes
    localparam logic [1:0] REG_DEBOUNCE  = 2'd0;
    localparam logic [1:0] REG_DTAP_WIN  = 2'd1;
    localparam logic [1:0] REG_LONG      = 2'd2;
    localparam logic [1:0] REG_VERY_LONG = 2'd3;

    // register reset values
    localparam logic [15:0] DEBOUNCE_RST  = 16'd30;
    localparam logic [15:0] DTAP_WIN_RST  = 16'd300;
    localparam logic [15:0] LONG_RST      = 16'd800;
    localparam logic [15:0] VERY_LONG_RST = 16'd3000;

    typedef struct packed {
        logic [15:0] debounce_time;
        logic [15:0] double_tap_window;
        logic [15:0] long_press_time;
        logic [15:0] very_long_press_time;
    } cfg_t;

    // up to two gestures produced by one event
    typedef struct packed {
        logic [1:0] count;
        logic [2:0] g0;
        logic [2:0] g1;
    } result_t;

    typedef struct packed {
        logic pressed;
        logic tap_pending;
        logic clear_fire;
    } eng_status_t;

    typedef struct packed {
        logic [2:0] count;
        logic       room;
    } fifo_status_t;

endpackage

// ===== design/tgr_engine.sv =====
`timescale 1ns / 1ps
// event input register, gesture state and single-pass event evaluation
module tgr_engine #(
    parameter int TIME_BITS = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            in_mode,
    input  logic [31:0]           in_timestamp,
    input  tgr_pkg::cfg_t         cfg,
    input  logic                  room,
    output tgr_pkg::result_t      result,
    output tgr_pkg::eng_status_t  status
);

    typedef logic [TIME_BITS-1:0] time_t;

    logic        in_vld_reg;
    logic [1:0]  in_mode_reg;
    time_t       in_time_reg;
    logic [63:0] ts_wide;
    logic        fire;

    logic  is_pressed_reg, is_pressed_next;
    time_t press_start_reg, press_start_next;
    logic  tap_pending_reg, tap_pending_next;
    time_t release_time_reg, release_time_next;
    logic  release_valid_reg, release_valid_next;
    time_t edge_time_reg, edge_time_next;
    logic  edge_valid_reg, edge_valid_next;
    logic  long_rep_reg, long_rep_next;
    logic  vlong_rep_reg, vlong_rep_next;

    time_t d_edge, d_rel, d_held;
    logic  bounced, in_window;

    assign ts_wide  = {32'd0, in_timestamp};
    assign fire     = in_vld_reg && room;
    assign in_ready = !in_vld_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (in_ready) begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            in_mode_reg <= in_mode;
            in_time_reg <= ts_wide[TIME_BITS-1:0];
        end
    end

    // modular time differences
    assign d_edge    = in_time_reg - edge_time_reg;
    assign d_rel     = in_time_reg - release_time_reg;
    assign d_held    = in_time_reg - press_start_reg;
    assign bounced   = edge_valid_reg && (d_edge < time_t'(cfg.debounce_time));
    assign in_window = d_rel <= time_t'(cfg.double_tap_window);

    always_comb begin
        is_pressed_next    = is_pressed_reg;
        press_start_next   = press_start_reg;
        tap_pending_next   = tap_pending_reg;
        release_time_next  = release_time_reg;
        release_valid_next = release_valid_reg;
        edge_time_next     = edge_time_reg;
        edge_valid_next    = edge_valid_reg;
        long_rep_next      = long_rep_reg;
        vlong_rep_next     = vlong_rep_reg;
        result.count       = 2'd0;
        result.g0          = tgr_pkg::G_DOWN;
        result.g1          = tgr_pkg::G_DOWN;
        unique case (in_mode_reg)
            tgr_pkg::MODE_PRESS: begin
                if (!bounced && !is_pressed_reg) begin
                    edge_time_next   = in_time_reg;
                    edge_valid_next  = 1'b1;
                    is_pressed_next  = 1'b1;
                    press_start_next = in_time_reg;
                    long_rep_next    = 1'b0;
                    vlong_rep_next   = 1'b0;
                    result.count     = 2'd1;
                    result.g0        = tgr_pkg::G_DOWN;
                end
            end
            tgr_pkg::MODE_RELEASE: begin
                if (is_pressed_reg && !bounced) begin
                    edge_time_next  = in_time_reg;
                    edge_valid_next = 1'b1;
                    is_pressed_next = 1'b0;
                    result.count    = 2'd1;
                    result.g0       = tgr_pkg::G_UP;
                    if (long_rep_reg || vlong_rep_reg) begin
                        tap_pending_next   = 1'b0;
                        release_valid_next = 1'b0;
                    end else if (tap_pending_reg && release_valid_reg && in_window) begin
                        tap_pending_next   = 1'b0;
                        release_valid_next = 1'b0;
                        result.count       = 2'd2;
                        result.g1          = tgr_pkg::G_DOUBLE;
                    end else begin
                        tap_pending_next   = 1'b1;
                        release_time_next  = in_time_reg;
                        release_valid_next = 1'b1;
                    end
                end
            end
            tgr_pkg::MODE_TICK: begin
                // press report goes first, tap second
                if (is_pressed_reg) begin
                    if (!vlong_rep_reg && d_held >= time_t'(cfg.very_long_press_time)) begin
                        vlong_rep_next = 1'b1;
                        result.count   = 2'd1;
                        result.g0      = tgr_pkg::G_VERY_LONG;
                    end else if (!long_rep_reg && d_held >= time_t'(cfg.long_press_time)) begin
                        long_rep_next = 1'b1;
                        result.count  = 2'd1;
                        result.g0     = tgr_pkg::G_LONG;
                    end
                end
                if (tap_pending_reg && release_valid_reg && !in_window) begin
                    tap_pending_next   = 1'b0;
                    release_valid_next = 1'b0;
                    if (result.count == 2'd0) begin
                        result.count = 2'd1;
                        result.g0    = tgr_pkg::G_SINGLE;
                    end else begin
                        result.count = 2'd2;
                        result.g1    = tgr_pkg::G_SINGLE;
                    end
                end
            end
            tgr_pkg::MODE_CLEAR: begin
                is_pressed_next    = 1'b0;
                press_start_next   = '0;
                tap_pending_next   = 1'b0;
                release_time_next  = '0;
                release_valid_next = 1'b0;
                edge_time_next     = '0;
                edge_valid_next    = 1'b0;
                long_rep_next      = 1'b0;
                vlong_rep_next     = 1'b0;
            end
            default: begin
            end
        endcase
        if (!fire) begin
            result.count = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            is_pressed_reg    <= 1'b0;
            press_start_reg   <= '0;
            tap_pending_reg   <= 1'b0;
            release_time_reg  <= '0;
            release_valid_reg <= 1'b0;
            edge_time_reg     <= '0;
            edge_valid_reg    <= 1'b0;
            long_rep_reg      <= 1'b0;
            vlong_rep_reg     <= 1'b0;
        end else if (fire) begin
            is_pressed_reg    <= is_pressed_next;
            press_start_reg   <= press_start_next;
            tap_pending_reg   <= tap_pending_next;
            release_time_reg  <= release_time_next;
            release_valid_reg <= release_valid_next;
            edge_time_reg     <= edge_time_next;
            edge_valid_reg    <= edge_valid_next;
            long_rep_reg      <= long_rep_next;
            vlong_rep_reg     <= vlong_rep_next;
        end
    end

    assign status.pressed     = is_pressed_reg;
    assign status.tap_pending = tap_pending_reg;
    assign status.clear_fire  = fire && (in_mode_reg == tgr_pkg::MODE_CLEAR);

endmodule

// ===== design/tgr_out_fifo.sv =====
`timescale 1ns / 1ps
// four-entry result queue taking up to two words per cycle
module tgr_out_fifo (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  tgr_pkg::result_t       push,
    output tgr_pkg::fifo_status_t  status,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [2:0]             out_gesture,
    output logic                   out_last
);

    logic [2:0] gest_mem [4];
    logic       last_mem [4];
    logic [1:0] wr_ptr_reg, rd_ptr_reg;
    logic [2:0] count_reg, count_next;
    logic       pop;
    logic [1:0] wr_ptr_1;

    assign out_valid   = count_reg != 3'd0;
    assign pop         = out_valid && out_ready;
    assign out_gesture = gest_mem[rd_ptr_reg];
    assign out_last    = last_mem[rd_ptr_reg];
    assign wr_ptr_1    = wr_ptr_reg + 2'd1;
    assign count_next  = count_reg + {1'b0, push.count} - {2'b00, pop};

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            gest_mem[wr_ptr_reg] <= push.g0;
            last_mem[wr_ptr_reg] <= (push.count == 2'd1);
        end
        if (push.count == 2'd2) begin
            gest_mem[wr_ptr_1] <= push.g1;
            last_mem[wr_ptr_1] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + push.count;
            rd_ptr_reg <= rd_ptr_reg + {1'b0, pop};
            count_reg  <= count_next;
        end
    end

    // room for a full two-word event
    assign status.room  = count_reg <= 3'd2;
    assign status.count = count_reg;

endmodule

// ===== design/touch_gesture_recognizer.sv =====
`timescale 1ns / 1ps
// touch gesture recogniser top level: config registers, engine and result queue
//
// takes timestamped press, release, tick and clear events (mode in s_axis_tuser,
// millisecond time in s_axis_tdata) and emits gesture words: touch-down, touch-up,
// single tap, double tap, long and very long press. an event lands in an input
// register and is evaluated against the gesture state; its zero, one or two
// words go into a four-entry result queue, the final word of an event marked
// with tlast. the first result word is valid on the master port once the event
// has been evaluated and its words written into the queue. the queue drains one
// word per cycle on the master port while m_axis_tready is high, so one word
// events sustain one per cycle and two word events a lower rate; an event is
// held in the input register while the queue has fewer than two free entries.
// time differences wrap modulo 2^TIME_BITS; the 32-bit timestamp is
// zero-extended or truncated to that width.
// configuration registers (debounce, double tap window, long and very long press
// times, 16 bits each) are written through cfg_wr_en/cfg_index/cfg_data and must
// only change while no event is in flight.
module touch_gesture_recognizer #(
    parameter int TIME_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input word
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] timestamp
    input  logic [1:0]  s_axis_tuser,   // [1:0] mode
    // result word
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [2:0] gesture, [7:3] zero
    output logic        m_axis_tlast,
    // config write port
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    tgr_pkg::cfg_t         cfg_reg;
    tgr_pkg::result_t      result;
    tgr_pkg::eng_status_t  eng_status;
    tgr_pkg::fifo_status_t fifo_status;
    logic [2:0]            gesture;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_time        <= tgr_pkg::DEBOUNCE_RST;
            cfg_reg.double_tap_window    <= tgr_pkg::DTAP_WIN_RST;
            cfg_reg.long_press_time      <= tgr_pkg::LONG_RST;
            cfg_reg.very_long_press_time <= tgr_pkg::VERY_LONG_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                tgr_pkg::REG_DEBOUNCE:  cfg_reg.debounce_time        <= cfg_data;
                tgr_pkg::REG_DTAP_WIN:  cfg_reg.double_tap_window    <= cfg_data;
                tgr_pkg::REG_LONG:      cfg_reg.long_press_time      <= cfg_data;
                tgr_pkg::REG_VERY_LONG: cfg_reg.very_long_press_time <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // debounce, tap and hold evaluation
    tgr_engine #(
        .TIME_BITS (TIME_BITS)
    ) u_engine (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .in_mode      (s_axis_tuser),
        .in_timestamp (s_axis_tdata),
        .cfg          (cfg_reg),
        .room         (fifo_status.room),
        .result       (result),
        .status       (eng_status)
    );

    // result queue, parts the engine from the master port
    tgr_out_fifo u_out_fifo (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push        (result),
        .status      (fifo_status),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_gesture (gesture),
        .out_last    (m_axis_tlast)
    );

    assign m_axis_tdata = {5'd0, gesture};

    // queue never overfills
    a_fifo_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_status.count <= 3'd4)
        else $error("result queue overflow");

    // a two-word event is only taken with room for both words
    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (result.count != 2'd0) |-> fifo_status.room)
        else $error("result pushed without room");

    // clear event leaves no hold and no pending tap
    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        eng_status.clear_fire |=> (!eng_status.pressed && !eng_status.tap_pending))
        else $error("state not cleared");

    // clear event never produces a word
    a_clear_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        eng_status.clear_fire |-> (result.count == 2'd0))
        else $error("clear produced a result");

endmodule
